/* src/integer_to_ascii_formatter_assert.svh */
// Assertion macros for the integer to ASCII formatter.
// Include guard keeps the macros defined once per compilation unit.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define IAF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoa: same-cycle check failed");

// Next-cycle implication.
`define IAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoa: next-cycle check failed");

`endif

/* src/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, codes, payload types and helpers of the integer formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int WORD_BITS  = 32;
   localparam int VALUE_W    = 32;
   localparam int MODE_W     = 2;
   localparam int CHAR_W     = 8;

   // decimal digits needed: floor(WORD_BITS * log10(2)) + 1
   localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
   localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int DIG_W      = NUM_DIGITS * 4;
   localparam int EXT_W      = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
   localparam int CNT_W      = $clog2(WORD_BITS + 1);
   localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
   localparam int IDX_W      = $clog2(NUM_DIGITS);

   localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HEX      = 2'd2;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h41;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last_char;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic conv_step;
      logic skip_step;
      logic put_sign;
      logic put_digit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done;
      logic top_zero;
      logic left_one;
      logic neg;
      logic out_free;
   } sts_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-4){1'b0}}, d};
      if (d < 4'd10) begin
         digit_char = CH_ZERO + d_ext;
      end else begin
         digit_char = CH_ALPHA + d_ext - 8'd10;
      end
   endfunction

endpackage

/* src/itoa_ctrl.sv */
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, binary-to-BCD shifts, leading-zero skip, sign, digits.
// ----------------------------------------------------------------------------
module itoa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::sts_type sts,
   output itoa_pkg::cmd_type cmd
);
   import itoa_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // hex loads with a zero shift count and falls straight through
            if (sts.conv_done) begin
               state_in = ST_SKIP;
            end else begin
               cmd.conv_step = 1'b1;
            end
         end
         ST_SKIP: begin
            if (sts.top_zero && !sts.left_one) begin
               cmd.skip_step = 1'b1;
            end else if (sts.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.put_sign = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.put_digit = 1'b1;
               if (sts.left_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/itoa_datapath.sv */
// ----------------------------------------------------------------------------
// itoa_datapath
// Magnitude, double-dabble digit register, digit pointer and output register.
// ----------------------------------------------------------------------------
module itoa_datapath (
   input  logic              clock,
   input  logic              reset,
   input  itoa_pkg::req_type req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output itoa_pkg::rsp_type rsp_data,
   input  itoa_pkg::cmd_type cmd,
   output itoa_pkg::sts_type sts
);
   import itoa_pkg::*;

   logic [WORD_BITS-1:0] mag_ff, mag_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LEFT_W-1:0]    left_ff, left_in;
   logic                 neg_ff, neg_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [EXT_W-1:0]     val_ext;
   logic [WORD_BITS-1:0] val_w;
   logic [WORD_BITS-1:0] load_mag;
   logic                 load_neg;
   logic                 load_hex;
   logic [DIG_W-1:0]     hex_dig;
   logic [DIG_W-1:0]     adj;
   logic [LEFT_W-1:0]    left_m1;
   logic [IDX_W-1:0]     top_idx;
   logic [3:0]           top_dig;

   always_comb begin
      val_ext              = '0;
      val_ext[VALUE_W-1:0] = req_data.value;
      val_w                = val_ext[WORD_BITS-1:0];
      load_hex             = req_data.mode[1];
      load_neg             = (req_data.mode == MODE_SIGNED) && val_w[WORD_BITS-1];
      // most negative value wraps to its true magnitude
      load_mag             = load_neg ? (~val_w + 1'b1) : val_w;
      hex_dig                = '0;
      hex_dig[WORD_BITS-1:0] = load_mag;
   end

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? (dig_ff[i*4 +: 4] + 4'd3)
                                                   : dig_ff[i*4 +: 4];
      end
   end

   assign left_m1 = left_ff - 1'b1;
   assign top_idx = left_m1[IDX_W-1:0];
   assign top_dig = dig_ff[top_idx*4 +: 4];

   assign sts.conv_done = (cnt_ff == '0);
   assign sts.top_zero  = (top_dig == 4'd0);
   assign sts.left_one  = (left_ff == LEFT_W'(1));
   assign sts.neg       = neg_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mag_in       = mag_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         mag_in  = load_mag;
         neg_in  = load_neg;
         if (load_hex) begin
            dig_in  = hex_dig;
            cnt_in  = '0;
            left_in = LEFT_W'(HEX_DIGITS);
         end else begin
            dig_in  = '0;
            cnt_in  = CNT_W'(WORD_BITS);
            left_in = LEFT_W'(DEC_DIGITS);
         end
      end else if (cmd.conv_step) begin
         dig_in = {adj[DIG_W-2:0], mag_ff[WORD_BITS-1]};
         mag_in = mag_ff << 1;
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.skip_step) begin
         left_in = left_m1;
      end

      priority if (cmd.put_sign) begin
         rsp_data_in.ascii_char = CH_MINUS;
         rsp_data_in.last_char  = 1'b0;
         rsp_valid_in           = 1'b1;
      end else if (cmd.put_digit) begin
         rsp_data_in.ascii_char = digit_char(top_dig);
         rsp_data_in.last_char  = sts.left_one;
         rsp_valid_in           = 1'b1;
         left_in                = left_m1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         // character still waiting to be taken
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         left_ff      <= LEFT_W'(1);
         neg_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         neg_ff       <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      dig_ff      <= dig_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/integer_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one word as unsigned decimal, signed decimal or upper-case hex text.
// ----------------------------------------------------------------------------
// One request at a time. A decimal request is loaded, then runs WORD_BITS
// (32) double-dabble shifts in the binary-to-BCD register and a check that the
// shifts have finished; a hex request skips the shifts. Leading zero digits
// are then dropped at one per cycle, the skip state picks sign or digits, and
// the characters (optional '-', then digits, most significant first) leave at
// one per cycle through an output register unless the receiver holds them
// back. A new request is taken the cycle after the last character has been
// handed to the output register.
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   itoa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   `IAF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `IAF_ASSERT_SAME(a_put_needs_slot, clock, reset, cmd.put_sign || cmd.put_digit, sts.out_free)
   `IAF_ASSERT_SAME(a_skip_keeps_one, clock, reset, cmd.skip_step, !sts.left_one)
   `IAF_ASSERT_SAME(a_one_command, clock, reset, 1'b1, $onehot0(cmd))

endmodule

/* test/integer_to_ascii_formatter_test.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_test
// Drives numbers in every format through the formatter and checks each
// character it returns against text predicted locally, with random gaps on
// the request side and random back-pressure on the character side.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;
   import itoa_pkg::*;

   // mode 3 is unused but formats as hex
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   class text_scoreboard;
      rsp_type pending_chars[$];
      int      bad_chars;

      task report_mismatch(string msg);
         $display("%0t: %s", $time, msg);
         bad_chars++;
      endtask

      // predicts the text of one accepted request
      function void note_number(req_type item);
         logic [WORD_BITS-1:0] mag;
         logic [3:0]           d;
         rsp_type              digits[$];
         rsp_type              c;
         bit                   hex;
         bit                   neg;
         hex = item.mode[1];
         mag = item.value[WORD_BITS-1:0];
         neg = !hex && item.mode == MODE_SIGNED && mag[WORD_BITS-1];
         if (neg) begin
            mag = -mag;
         end
         do begin
            if (hex) begin
               d   = mag[3:0];
               mag = mag >> 4;
            end else begin
               d   = 4'(mag % 10);
               mag = mag / 10;
            end
            c.ascii_char = (d < 10) ? CH_ZERO + d : CH_ALPHA + (d - 4'd10);
            c.last_char  = (digits.size() == 0);
            digits.push_front(c);
         end while (mag != 0);
         if (neg) begin
            c.ascii_char = CH_MINUS;
            c.last_char  = 1'b0;
            digits.push_front(c);
         end
         foreach (digits[i]) pending_chars.push_back(digits[i]);
      endfunction

      task check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char %h last %b",
                                      got.ascii_char, got.last_char));
         end else begin
            want = pending_chars.pop_front();
            if (got.ascii_char !== want.ascii_char)
               report_mismatch($sformatf("char %h, wanted %h",
                                         got.ascii_char, want.ascii_char));
            if (got.last_char !== want.last_char)
               report_mismatch($sformatf("last flag %b, wanted %b on char %h",
                                         got.last_char, want.last_char, want.ascii_char));
         end
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   text_scoreboard sb;
   bit             steady = 1'b0;   // no idling on either side while set

   integer_to_ascii_formatter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task send_number(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
      req_type item;
      int      gap;
      item.mode  = mode;
      item.value = value;
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_number(item);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] p;
      case ($urandom_range(0, 5))
         0: pick_value = $urandom;
         1: pick_value = $urandom_range(0, 999);
         2: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            pick_value = p + $urandom_range(0, 2) - 1;
         end
         3: pick_value = -$urandom_range(1, 1000);
         4: pick_value = 32'd1 << $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 2))
               0: pick_value = 32'h8000_0000;
               1: pick_value = 32'h7FFF_FFFF;
               default: pick_value = 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // character side: random back-pressure per character
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_char(rsp_data);
      end
   end

   initial begin
      logic [MODE_W-1:0] mode;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_number(MODE_UNSIGNED, 32'd0);
      send_number(MODE_SIGNED,   32'd0);
      send_number(MODE_HEX,      32'd0);
      send_number(MODE_SPARE,    32'd0);
      send_number(MODE_UNSIGNED, 32'hFFFF_FFFF);
      send_number(MODE_SIGNED,   32'hFFFF_FFFF);
      send_number(MODE_HEX,      32'hFFFF_FFFF);
      send_number(MODE_SIGNED,   32'h8000_0000);   // most negative
      send_number(MODE_SIGNED,   32'h7FFF_FFFF);
      send_number(MODE_UNSIGNED, 32'h8000_0000);
      send_number(MODE_HEX,      32'h8000_0000);
      send_number(MODE_UNSIGNED, 32'd9);
      send_number(MODE_UNSIGNED, 32'd10);
      send_number(MODE_UNSIGNED, 32'd1000000000);
      send_number(MODE_UNSIGNED, 32'd999999999);
      send_number(MODE_SIGNED,   -32'd1000);
      send_number(MODE_HEX,      32'hABCD_EF01);
      send_number(MODE_SPARE,    32'hFEDC_BA98);
      send_number(MODE_HEX,      32'd1);
      send_number(MODE_SIGNED,   32'd1);
      send_number(MODE_HEX,      32'h0000_000F);

      for (int i = 0; i < 190; i++) begin
         steady = (i % 50) < 12;
         mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : MODE_W'($urandom_range(0, 2));
         send_number(mode, pick_value());
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (sb.bad_chars == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/itoa_pkg.sv
src/itoa_ctrl.sv
src/itoa_datapath.sv
src/integer_to_ascii_formatter.sv
test/integer_to_ascii_formatter_test.sv
